// File: rtl/hqp_pkg.sv
// ----------------------------------------------------------------------------
// hqp_pkg
// Shared types and constants of the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package hqp_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int SIZE_W     = 11;
  localparam int KEY_BYTES  = 8;
  localparam int KEY_W      = 64;
  localparam int LEN_W      = 4;
  localparam int VALUE_BITS = 32;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int PROD_W     = 64;
  localparam int MOD_BITS   = 4;                  // remainder bits per cycle
  localparam int MOD_STEPS  = PROD_W / MOD_BITS;
  localparam int MODCNT_W   = $clog2(MOD_STEPS);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SLOTS);

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

  typedef struct packed {
    logic                  used;
    logic [KEY_W-1:0]      key;
    logic [LEN_W-1:0]      len;
    logic [VALUE_BITS-1:0] payload;
    logic [SLOT_W-1:0]     home;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_READ, S_CHECK, S_CLEAR, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    H_IDLE, H_MUL, H_MOD
  } hash_state_t;

endpackage

// File: rtl/hash_table_quadratic_probe.sv
// ----------------------------------------------------------------------------
// hash_table_quadratic_probe
// Open-addressing hash table with quadratic probing over one slot RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_SLOTS slots of the RAM before it
// takes the first item; a clear item runs the same sweep. Insert and
// search first form the home slot (byte-serial multiply over the key
// bytes, 4-bit-per-cycle remainder, then a handoff), then probe: each
// probe is a RAM read followed by a compare and write back. An accept
// step comes before and a result load after. An invalid command goes
// straight from acceptance to the result. One item is in flight at a
// time; a new item is taken while the previous result waits in the
// output register.
module hash_table_quadratic_probe (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hqp_pkg::SIZE_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hqp_pkg::CMD_W-1:0]        command,
  input  logic [hqp_pkg::KEY_W-1:0]        key_chars,
  input  logic [hqp_pkg::LEN_W-1:0]        key_length,
  input  logic [hqp_pkg::VALUE_BITS-1:0]   entry_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hqp_pkg::STATUS_W-1:0]     status,
  output logic [hqp_pkg::SLOT_W-1:0]       slot_index,
  output logic [hqp_pkg::SLOT_W-1:0]       home_slot,
  output logic [hqp_pkg::SIZE_W-1:0]       probe_count,
  output logic [hqp_pkg::VALUE_BITS-1:0]   found_value
);

  import hqp_pkg::*;

  state_t                state, state_next;
  logic [SIZE_W-1:0]     table_size;
  logic [SIZE_W-1:0]     size;
  logic [SIZE_W-1:0]     size_in;
  logic [CMD_W-1:0]      cmd;
  logic [KEY_W-1:0]      key;
  logic [KEY_W-1:0]      key_in;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      len_in;
  logic [VALUE_BITS-1:0] payload;
  logic [SLOT_W-1:0]     home;
  logic [SLOT_W-1:0]     q;
  logic [SLOT_W-1:0]     d;
  logic [SIZE_W-1:0]     k;
  logic [SLOT_W-1:0]     slot;
  logic [SIZE_W-1:0]     sweep;
  logic [SIZE_W-1:0]     q_sum, d_sum, s_sum, k_inc;
  logic                  hash_start, hash_done;
  logic [SLOT_W-1:0]     hash_home;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  slot_t                 ram_wdata;
  slot_t                 ram_rdata;
  logic                  hit, probe_end;
  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [SIZE_W-1:0]     res_probes;
  logic [VALUE_BITS-1:0] res_value;
  logic                  accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  // Clamp the size and mask the key at acceptance.
  always_comb begin
    size_in = table_size;
    if (table_size < SIZE_MIN) size_in = SIZE_MIN;
    if (table_size > SIZE_MAX) size_in = SIZE_MAX;
    len_in = (key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_length;
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_in[b*8 +: 8] = (LEN_W'(b) < len_in) ? key_chars[b*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // The hash unit latches key and length at the accepting edge.
  hqp_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_in),
    .len   (len_in),
    .size  (size),
    .done  (hash_done),
    .home  (hash_home)
  );

  // Incremental k*k mod size: q += d, d += 2, each one compare-subtract.
  always_comb begin
    q_sum = SIZE_W'(q) + SIZE_W'(d);
    if (q_sum >= size) q_sum = q_sum - size;
    d_sum = SIZE_W'(d) + SIZE_W'(2);
    if (d_sum >= size) d_sum = d_sum - size;
    s_sum = SIZE_W'(home) + SIZE_W'(q);
    if (s_sum >= size) s_sum = s_sum - size;
    k_inc = k + SIZE_W'(1);
  end

  assign hit       = ram_rdata.used && (ram_rdata.key == key) && (ram_rdata.len == len);
  assign probe_end = (k_inc >= size);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = '{used: 1'b1, key: key, len: len, payload: payload, home: home};
    if (state == S_INIT || state == S_CLEAR) begin
      ram_we         = 1'b1;
      ram_waddr      = sweep[SLOT_W-1:0];
      ram_wdata.used = 1'b0;
    end else if (state == S_CHECK && cmd == CMD_INSERT && !ram_rdata.used) begin
      ram_we = 1'b1;
    end
  end

  hqp_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s_sum[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  assign hash_start = (state == S_IDLE) && accept &&
                      (command == CMD_INSERT || command == CMD_SEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep == SIZE_W'(MAX_SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_CLEAR:               state_next = S_CLEAR;
            CMD_INSERT, CMD_SEARCH:  state_next = S_HASH;
            default:                 state_next = S_DONE;
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) state_next = S_READ;
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (!ram_rdata.used || (cmd == CMD_SEARCH && hit) || probe_end) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_CLEAR: begin
        if (sweep == SIZE_W'(MAX_SLOTS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  function automatic logic [SIZE_W-1:0] k_inc_sweep(input logic [SIZE_W-1:0] v);
    k_inc_sweep = v + SIZE_W'(1);
  endfunction

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else begin
      case (state)
        S_INIT, S_CLEAR: sweep <= k_inc_sweep(sweep);
        default:         sweep <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd        <= command;
          key        <= key_in;
          len        <= len_in;
          payload    <= entry_value;
          size       <= size_in;
          home       <= '0;
          res_status <= (command == CMD_CLEAR) ? ST_CLEARED : ST_NOT_FOUND;
          res_slot   <= '0;
          res_probes <= '0;
          res_value  <= '0;
        end
      end
      S_HASH: begin
        home <= hash_home;
        q    <= '0;
        d    <= SLOT_W'(1);
        k    <= '0;
      end
      S_READ: begin
        slot <= s_sum[SLOT_W-1:0];
      end
      S_CHECK: begin
        q <= q_sum[SLOT_W-1:0];
        d <= d_sum[SLOT_W-1:0];
        k <= k_inc;
        res_probes <= k_inc;
        if (cmd == CMD_INSERT) begin
          if (!ram_rdata.used) begin
            res_status <= ST_INSERTED;
            res_slot   <= slot;
          end else begin
            res_status <= ST_FULL;
          end
        end else if (hit) begin
          res_status <= ST_FOUND;
          res_slot   <= slot;
          res_value  <= ram_rdata.payload;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status      <= res_status;
      slot_index  <= res_slot;
      home_slot   <= home;
      probe_count <= res_probes;
      found_value <= res_value;
    end
  end

endmodule

// File: rtl/hqp_ram.sv
// ----------------------------------------------------------------------------
// hqp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hqp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hqp_hash.sv
// ----------------------------------------------------------------------------
// hqp_hash
// Home slot unit: byte-serial 64-bit product, then radix-16 remainder.
// ----------------------------------------------------------------------------
module hqp_hash (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hqp_pkg::KEY_W-1:0]    key,
  input  logic [hqp_pkg::LEN_W-1:0]    len,
  input  logic [hqp_pkg::SIZE_W-1:0]   size,
  output logic                         done,
  output logic [hqp_pkg::SLOT_W-1:0]   home
);

  import hqp_pkg::*;

  hash_state_t          hstate;
  logic [PROD_W-1:0]    prod;
  logic [KEY_W-1:0]     kshift;
  logic [LEN_W-1:0]     cnt;
  logic [MODCNT_W-1:0]  modcnt;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    rem_next;
  logic [PROD_W-1:0]    prod_shift;

  // Four restoring steps; remainder stays below size, so 2r+1 fits.
  always_comb begin
    rem_next   = rem;
    prod_shift = prod;
    for (int j = 0; j < MOD_BITS; j++) begin
      rem_next   = {rem_next[SIZE_W-2:0], prod_shift[PROD_W-1]};
      prod_shift = {prod_shift[PROD_W-2:0], 1'b0};
      if (rem_next >= size) begin
        rem_next = rem_next - size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (hstate)
        H_IDLE: begin
          if (start) begin
            hstate <= H_MUL;
          end
        end
        H_MUL: begin
          if (cnt == '0) begin
            hstate <= H_MOD;
          end
        end
        H_MOD: begin
          if (modcnt == MODCNT_W'(MOD_STEPS - 1)) begin
            hstate <= H_IDLE;
            done   <= 1'b1;
          end
        end
        default: hstate <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (hstate)
      H_IDLE: begin
        prod   <= PROD_W'(1);
        kshift <= key;
        cnt    <= len;
        modcnt <= '0;
        rem    <= '0;
      end
      H_MUL: begin
        if (cnt != '0) begin
          prod   <= prod * PROD_W'(kshift[7:0]);
          kshift <= kshift >> 8;
          cnt    <= cnt - LEN_W'(1);
        end
      end
      H_MOD: begin
        rem    <= rem_next;
        prod   <= prod_shift;
        modcnt <= modcnt + MODCNT_W'(1);
        if (modcnt == MODCNT_W'(MOD_STEPS - 1)) begin
          home <= rem_next[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/hqp_checker.sv
// ----------------------------------------------------------------------------
// hqp_checker
// Port-level checks of the hash table results, bound to the top level.
// ----------------------------------------------------------------------------
module hqp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [hqp_pkg::STATUS_W-1:0]     status,
  input logic [hqp_pkg::SLOT_W-1:0]       slot_index,
  input logic [hqp_pkg::SIZE_W-1:0]       probe_count,
  input logic [hqp_pkg::VALUE_BITS-1:0]   found_value
);

  import hqp_pkg::*;

  // Hold a stalled item.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index))
    else $error("result changed while stalled");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_CLEARED |-> slot_index == '0 && probe_count == '0)
    else $error("clear result carries slot or probes");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_FOUND || status == ST_FULL)
    |-> slot_index == '0 && found_value == '0)
    else $error("miss result carries slot or value");

  a_probes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED || status == ST_FOUND || status == ST_FULL)
    |-> probe_count != '0 && probe_count <= SIZE_W'(MAX_SLOTS))
    else $error("probe count out of range");

endmodule

bind hash_table_quadratic_probe hqp_checker u_hqp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .slot_index  (slot_index),
  .probe_count (probe_count),
  .found_value (found_value)
);
